>>> rtl/wtcsu_pkg.sv
`timescale 1ns / 1ps

package wtcsu_pkg;

  localparam int unsigned WordW = 36;
  localparam int unsigned HalfW = 18;

  localparam logic [HalfW-1:0] H10MASK = 18'h3FFFF;
  localparam logic [WordW-1:0] SIGN36  = 36'h800000000;
  localparam logic [WordW-1:0] LOW35   = 36'h7FFFFFFFF;

  // program-counter actions
  localparam logic [1:0] PCINC_1 = 2'd0;  // next instruction
  localparam logic [1:0] PCINC_2 = 2'd1;  // skip one
  localparam logic [1:0] PCINC_0 = 2'd2;  // jump to immediate

  // instruction groups
  localparam logic [3:0] KIND_TL   = 4'd0;
  localparam logic [3:0] KIND_TR   = 4'd1;
  localparam logic [3:0] KIND_TD   = 4'd2;
  localparam logic [3:0] KIND_TS   = 4'd3;
  localparam logic [3:0] KIND_AOBJ = 4'd4;
  localparam logic [3:0] KIND_CAI  = 4'd5;
  localparam logic [3:0] KIND_CAM  = 4'd6;
  localparam logic [3:0] KIND_JUMP = 4'd7;
  localparam logic [3:0] KIND_SKIP = 4'd8;
  localparam logic [3:0] KIND_AOS  = 4'd9;
  localparam logic [3:0] KIND_SOS  = 4'd10;
  localparam logic [3:0] KIND_AOJ  = 4'd11;
  localparam logic [3:0] KIND_SOJ  = 4'd12;

  // test modify codes
  localparam logic [1:0] MOD_NONE = 2'd0;
  localparam logic [1:0] MOD_ZERO = 2'd1;
  localparam logic [1:0] MOD_SET  = 2'd2;
  localparam logic [1:0] MOD_COMP = 2'd3;

  // one instruction as it enters the unit
  typedef struct packed {
    logic [3:0]       kind;
    logic [1:0]       modify_code;
    logic [2:0]       condition;
    logic [WordW-1:0] ac_value;
    logic [WordW-1:0] mem_value;
    logic [HalfW-1:0] immediate;
    logic             ac_nonzero;
  } op_t;

  // after execute: words and flags settled, the signed compare still pending
  typedef struct packed {
    logic             ac_write;
    logic [WordW-1:0] ac_result;
    logic             mem_write;
    logic [WordW-1:0] mem_result;
    logic             carry_zero;
    logic             carry_one;
    logic             overflow;
    logic [1:0]       pc_fixed;
    logic             rel_en;
    logic [1:0]       rel_pc;
    logic [2:0]       condition;
    logic [WordW-1:0] cmp_a;
    logic [WordW-1:0] cmp_b;
  } mid_t;

  // one result item
  typedef struct packed {
    logic             ac_write;
    logic [WordW-1:0] ac_result;
    logic             mem_write;
    logic [WordW-1:0] mem_result;
    logic [1:0]       pc_action;
    logic             carry_zero;
    logic             carry_one;
    logic             overflow;
  } res_t;

endpackage

>>> rtl/wtcsu_exec.sv
`timescale 1ns / 1ps

module wtcsu_exec (
  input  wtcsu_pkg::op_t  op_i,
  output wtcsu_pkg::mid_t mid_o
);
  import wtcsu_pkg::*;

  logic [WordW-1:0] tw, tmask, tmasked, tmod;
  logic             tpass;
  logic [WordW-1:0] idw, idsum;
  logic             inc;
  logic [HalfW-1:0] lh, rh;

  // test operands
  always_comb begin
    unique case (op_i.kind)
      KIND_TL: begin
        tw    = {{HalfW{1'b0}}, op_i.ac_value[WordW-1:HalfW]};
        tmask = {{HalfW{1'b0}}, op_i.immediate};
      end
      KIND_TR: begin
        tw    = {{HalfW{1'b0}}, op_i.ac_value[HalfW-1:0]};
        tmask = {{HalfW{1'b0}}, op_i.immediate};
      end
      KIND_TS: begin
        tw    = op_i.ac_value;
        tmask = {op_i.mem_value[HalfW-1:0], op_i.mem_value[WordW-1:HalfW]};
      end
      default: begin
        tw    = op_i.ac_value;
        tmask = op_i.mem_value;
      end
    endcase
  end

  assign tmasked = tw & tmask;
  assign tpass   = op_i.condition[0] ? (op_i.condition[1] ? (tmasked != '0) : (tmasked == '0))
                                     : op_i.condition[1];

  always_comb begin
    unique case (op_i.modify_code)
      MOD_ZERO: tmod = tw & ~tmask;
      MOD_SET:  tmod = tw | tmask;
      MOD_COMP: tmod = tw ^ tmask;
      default:  tmod = tw;
    endcase
  end

  // shared increment / decrement adder
  assign inc   = (op_i.kind == KIND_AOS) || (op_i.kind == KIND_AOJ);
  assign idw   = ((op_i.kind == KIND_AOS) || (op_i.kind == KIND_SOS)) ? op_i.mem_value
                                                                    : op_i.ac_value;
  assign idsum = idw + (inc ? {{(WordW-1){1'b0}}, 1'b1} : {WordW{1'b1}});

  // half-word counters for aobj
  assign lh = op_i.ac_value[WordW-1:HalfW] + {{(HalfW-1){1'b0}}, 1'b1};
  assign rh = op_i.ac_value[HalfW-1:0] + {{(HalfW-1){1'b0}}, 1'b1};

  always_comb begin
    mid_o            = '0;
    mid_o.ac_result  = op_i.ac_value;
    mid_o.mem_result = op_i.mem_value;
    mid_o.pc_fixed   = PCINC_1;
    mid_o.rel_pc     = PCINC_2;
    mid_o.condition  = op_i.condition;
    mid_o.cmp_a      = op_i.ac_value;
    unique case (op_i.kind)
      KIND_TL, KIND_TR, KIND_TD, KIND_TS: begin
        mid_o.ac_write = (op_i.modify_code != MOD_NONE);
        mid_o.pc_fixed = tpass ? PCINC_2 : PCINC_1;
        if (op_i.kind == KIND_TL) begin
          mid_o.ac_result = {tmod[HalfW-1:0], op_i.ac_value[HalfW-1:0]};
        end else if (op_i.kind == KIND_TR) begin
          mid_o.ac_result = {op_i.ac_value[WordW-1:HalfW], tmod[HalfW-1:0]};
        end else begin
          mid_o.ac_result = tmod;
        end
      end
      KIND_AOBJ: begin
        mid_o.ac_write  = 1'b1;
        mid_o.ac_result = {lh, rh};
        mid_o.pc_fixed  = (lh[HalfW-1] == op_i.condition[0]) ? PCINC_0 : PCINC_1;
      end
      KIND_CAI: begin
        mid_o.rel_en = 1'b1;
        mid_o.cmp_b  = {{HalfW{1'b0}}, op_i.immediate};
      end
      KIND_CAM: begin
        mid_o.rel_en = 1'b1;
        mid_o.cmp_b  = op_i.mem_value;
      end
      KIND_JUMP: begin
        mid_o.rel_en = 1'b1;
        mid_o.rel_pc = PCINC_0;
      end
      KIND_SKIP: begin
        mid_o.rel_en = 1'b1;
        mid_o.cmp_a  = op_i.mem_value;
        if (op_i.ac_nonzero) begin
          mid_o.ac_write  = 1'b1;
          mid_o.ac_result = op_i.mem_value;
        end
      end
      KIND_AOS, KIND_SOS, KIND_AOJ, KIND_SOJ: begin
        if (inc) begin
          mid_o.carry_one  = &idw[WordW-2:0];
          mid_o.carry_zero = &idw;
          mid_o.overflow   = (idw == LOW35);
        end else begin
          mid_o.carry_zero = |idw;
          mid_o.carry_one  = |idw[WordW-2:0];
          mid_o.overflow   = (idw == SIGN36);
        end
        mid_o.rel_en = 1'b1;
        mid_o.cmp_a  = idsum;
        if ((op_i.kind == KIND_AOS) || (op_i.kind == KIND_SOS)) begin
          mid_o.mem_write  = 1'b1;
          mid_o.mem_result = idsum;
          if (op_i.ac_nonzero) begin
            mid_o.ac_write  = 1'b1;
            mid_o.ac_result = idsum;
          end
        end else begin
          mid_o.ac_write  = 1'b1;
          mid_o.ac_result = idsum;
          mid_o.rel_pc    = PCINC_0;
        end
      end
      default: begin
        mid_o.pc_fixed = PCINC_1;
      end
    endcase
  end

endmodule

>>> rtl/wtcsu_resolve.sv
`timescale 1ns / 1ps

module wtcsu_resolve (
  input  wtcsu_pkg::mid_t mid_i,
  output wtcsu_pkg::res_t res_o
);
  import wtcsu_pkg::*;

  logic lt, eq, rel, hit;

  // signed 36-bit relation under the eight-way condition
  assign lt = $signed(mid_i.cmp_a) < $signed(mid_i.cmp_b);
  assign eq = (mid_i.cmp_a == mid_i.cmp_b);

  always_comb begin
    unique case (mid_i.condition[1:0])
      2'd0:    rel = 1'b0;
      2'd1:    rel = lt;
      2'd2:    rel = eq;
      default: rel = lt | eq;
    endcase
  end

  assign hit = rel ^ mid_i.condition[2];

  always_comb begin
    res_o.ac_write   = mid_i.ac_write;
    res_o.ac_result  = mid_i.ac_result;
    res_o.mem_write  = mid_i.mem_write;
    res_o.mem_result = mid_i.mem_result;
    res_o.carry_zero = mid_i.carry_zero;
    res_o.carry_one  = mid_i.carry_one;
    res_o.overflow   = mid_i.overflow;
    if (mid_i.rel_en) begin
      res_o.pc_action = hit ? mid_i.rel_pc : PCINC_1;
    end else begin
      res_o.pc_action = mid_i.pc_fixed;
    end
  end

endmodule

>>> rtl/word_test_compare_skip_unit_top.sv
`timescale 1ns / 1ps

// channel | handshake                    | payload
// --------+------------------------------+-------------------------------------------
// input   | in_valid_i / in_stall_o      | kind, modify_code, condition, ac_value,
//         |                              | mem_value, immediate, ac_nonzero
// output  | out_valid_o / out_stall_i    | ac_write, ac_result, mem_write, mem_result,
//         |                              | pc_action, carry_zero, carry_one, overflow
//
// one transfer per cycle sustained while out_stall_i is low; stages: input register,
// execute register (test/modify, aobj halves, 36-bit increment/decrement adder),
// output register (36-bit signed compare and pc selection)
// rst_ni clears only the stage valid bits; payload registers are not reset
// a stall on the output holds every occupied stage; empty stages still fill, so
// bubbles close up and in_stall_o rises only when all three stages are full

module word_test_compare_skip_unit_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [3:0]                kind_i,
  input  logic [1:0]                modify_code_i,
  input  logic [2:0]                condition_i,
  input  logic [wtcsu_pkg::WordW-1:0] ac_value_i,
  input  logic [wtcsu_pkg::WordW-1:0] mem_value_i,
  input  logic [wtcsu_pkg::HalfW-1:0] immediate_i,
  input  logic                      ac_nonzero_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      ac_write_o,
  output logic [wtcsu_pkg::WordW-1:0] ac_result_o,
  output logic                      mem_write_o,
  output logic [wtcsu_pkg::WordW-1:0] mem_result_o,
  output logic [1:0]                pc_action_o,
  output logic                      carry_zero_o,
  output logic                      carry_one_o,
  output logic                      overflow_o
);
  import wtcsu_pkg::*;

  // stage valid bits
  logic v1_q, v2_q, v3_q;
  // stage payloads
  op_t  op_d, op_q;
  mid_t mid_d, mid_q;
  res_t res_d, res_q;
  // a stage may load when it is empty or its content moves on
  logic adv1, adv2, adv3;

  assign adv3 = !v3_q || !out_stall_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_stall_o = !adv1;

  // stage 1: capture the instruction
  always_comb begin
    op_d.kind        = kind_i;
    op_d.modify_code = modify_code_i;
    op_d.condition   = condition_i;
    op_d.ac_value    = ac_value_i;
    op_d.mem_value   = mem_value_i;
    op_d.immediate   = immediate_i;
    op_d.ac_nonzero  = ac_nonzero_i;
  end

  // stage 2: execute words and flags
  wtcsu_exec u_exec (
    .op_i  (op_q),
    .mid_o (mid_d)
  );

  // stage 3: signed compare and pc action
  wtcsu_resolve u_resolve (
    .mid_i (mid_q),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) op_q  <= op_d;
    if (adv2 && v1_q)       mid_q <= mid_d;
    if (adv3 && v2_q)       res_q <= res_d;
  end

  assign out_valid_o  = v3_q;
  assign ac_write_o   = res_q.ac_write;
  assign ac_result_o  = res_q.ac_result;
  assign mem_write_o  = res_q.mem_write;
  assign mem_result_o = res_q.mem_result;
  assign pc_action_o  = res_q.pc_action;
  assign carry_zero_o = res_q.carry_zero;
  assign carry_one_o  = res_q.carry_one;
  assign overflow_o   = res_q.overflow;

endmodule

>>> rtl/wtcsu_checker.sv
`timescale 1ns / 1ps

module wtcsu_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [3:0]                  kind_i,
  input logic [1:0]                  modify_code_i,
  input logic [2:0]                  condition_i,
  input logic [wtcsu_pkg::WordW-1:0] ac_value_i,
  input logic [wtcsu_pkg::WordW-1:0] mem_value_i,
  input logic [wtcsu_pkg::HalfW-1:0] immediate_i,
  input logic                        ac_nonzero_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        ac_write_o,
  input logic [wtcsu_pkg::WordW-1:0] ac_result_o,
  input logic                        mem_write_o,
  input logic [wtcsu_pkg::WordW-1:0] mem_result_o,
  input logic [1:0]                  pc_action_o,
  input logic                        carry_zero_o,
  input logic                        carry_one_o,
  input logic                        overflow_o
);
  import wtcsu_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(ac_result_o)
      && $stable(mem_result_o) && $stable(pc_action_o))
    else $error("stalled result changed");

  // memory writes come only from aos/sos, which skip but never jump
  a_mem_no_jump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mem_write_o |-> pc_action_o != PCINC_0)
    else $error("memory write with jump");

  // pc action is one of the three defined codes
  a_pc_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pc_action_o == PCINC_1 || pc_action_o == PCINC_2
      || pc_action_o == PCINC_0)
    else $error("undefined pc action");

  // flags come only from increment/decrement, which always write a word
  a_flags_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (carry_zero_o || carry_one_o || overflow_o)
      |-> ac_write_o || mem_write_o)
    else $error("flags without a write");

endmodule

bind word_test_compare_skip_unit_top wtcsu_checker u_wtcsu_checker (.*);
